/* rtl/lfcas_pkg.sv */
`default_nettype none

package lfcas_pkg;

  localparam int TIME_W     = 48;
  localparam int ADD_W      = 57;
  localparam int UNITS_W    = 13;
  localparam int MSG_W      = 14;
  localparam int Q_W        = 16;
  localparam int UB_W       = 11;
  localparam int DVD_W      = 13;
  localparam int TPB_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int HDR_W      = 4;
  localparam int LAT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CNT_W      = 6;
  localparam int MASK_W     = 4;
  localparam int MUL1_STEPS = UB_W;
  localparam int MUL2_STEPS = TPB_W;

  localparam logic [TIME_W-1:0]  TIME_MAX       = {TIME_W{1'b1}};
  localparam logic [UNITS_W-1:0] UNITS_MAX      = {UNITS_W{1'b1}};
  localparam logic [UB_W-1:0]    SLOT_MODE_FLIT = UB_W'(256);

  typedef enum logic [1:0] {
    OP_REQ_ARRIVE = 2'd0,
    OP_RSP_ARRIVE = 2'd1,
    OP_REQ_DEQ    = 2'd2,
    OP_RSP_DEQ    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RETRY     = 3'd1,
    ST_REQ_FULL  = 3'd2,
    ST_RSP_FULL  = 3'd3,
    ST_EXCEEDS   = 3'd4,
    ST_SHORT     = 3'd5,
    ST_UNDERFLOW = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLIT_BYTES   = 3'd0,
    CFG_TICKS_PER_B  = 3'd1,
    CFG_REQ_LATENCY  = 3'd2,
    CFG_RSP_LATENCY  = 3'd3,
    CFG_REQ_HDR      = 3'd4,
    CFG_RSP_HDR      = 3'd5,
    CFG_REQ_DEPTH    = 3'd6,
    CFG_RSP_DEPTH    = 3'd7
  } cfg_idx_t;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_DIV   = 11'b000_0000_0010,
    S_UNITS = 11'b000_0000_0100,
    S_CHECK = 11'b000_0000_1000,
    S_MUL1  = 11'b000_0001_0000,
    S_MUL2  = 11'b000_0010_0000,
    S_ROUND = 11'b000_0100_0000,
    S_START = 11'b000_1000_0000,
    S_WAIT  = 11'b001_0000_0000,
    S_BUSY  = 11'b010_0000_0000,
    S_READY = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [1:0]         port;
    logic [TIME_W-1:0]  arrival_time;
    logic [DVD_W-1:0]   size_bytes;
    logic               is_write;
    logic               needs_response;
    logic               response_will_carry_data;
    logic               carries_data;
    logic [UNITS_W-1:0] dequeue_units;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         status;
    logic [UNITS_W-1:0] units;
    logic [TIME_W-1:0]  ready_time;
    logic [TIME_W-1:0]  queue_wait;
    logic [TIME_W-1:0]  serialize_ticks;
    logic [MASK_W-1:0]  retry_mask;
  } out_item_t;

  typedef struct packed {
    logic [ADD_W-1:0] a;
    logic [ADD_W-1:0] b;
    logic             cin;
  } add_req_t;

endpackage

`default_nettype wire

/* rtl/lfcas_in_if.sv */
`default_nettype none

interface lfcas_in_if
  import lfcas_pkg::*;
  ;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/lfcas_out_if.sv */
`default_nettype none

interface lfcas_out_if
  import lfcas_pkg::*;
  ;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/lfcas_addsub.sv */
`default_nettype none

module lfcas_addsub
  import lfcas_pkg::*;
(
  input  add_req_t         req,
  output logic [ADD_W:0]   sum
);

  assign sum = {1'b0, req.a} + {1'b0, req.b} + {{ADD_W{1'b0}}, req.cin};

endmodule

`default_nettype wire

/* rtl/link_flit_credit_admission_scheduler.sv */
// channel | dir | handshake         | beat
// in_ch   | in  | valid/ready       | one operation (arrival or dequeue)
// out_ch  | out | valid/ready       | one result per operation
// cfg_*   | in  | we, no back-press | one register write
//
// one operation at a time; in_ch.ready is high only when the sequencer is idle
// accepted arrival: 13 divide steps, then 11 + 32 multiply steps; a rejected
// arrival skips the multiply, a dequeue both; the shared adder sets the pace
// out_ch holds its beat until taken; the next operation waits in its last state
// synchronous active-low reset, no clearing pass
`default_nettype none

module link_flit_credit_admission_scheduler
  import lfcas_pkg::*;
#(
  parameter int NUM_PORTS = 4,
  parameter int SLOT_LEN  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lfcas_in_if.sink                   in_ch,
  lfcas_out_if.source                out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam logic [UB_W-1:0] SLOT_UB = UB_W'(SLOT_LEN);

  state_t state_r, state_nxt;

  logic [UB_W-1:0]  flit_r;
  logic [TPB_W-1:0] tpb_r;
  logic [LAT_W-1:0] req_lat_r, rsp_lat_r;
  logic [HDR_W-1:0] req_hdr_r, rsp_hdr_r;
  logic [Q_W-1:0]   req_depth_r, rsp_depth_r;

  logic [TIME_W-1:0]    req_busy_r, rsp_busy_r;
  logic [Q_W-1:0]       req_q_r, rsp_q_r, res_r;
  logic [NUM_PORTS-1:0] retry_r;

  in_item_t          item_r;
  opcode_t           op_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [UB_W-1:0]   rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ADD_W-1:0]  acc_r, mcand_r;
  logic [TPB_W-1:0]  mplier_r;
  logic [MSG_W-1:0]  msg_u_r, rsp_u_r;
  logic [TIME_W-1:0] start_r, wait_r, ser_r;
  logic              accepted_r;
  status_t           status_r;
  logic [UNITS_W-1:0] units_r;
  logic [MASK_W-1:0] mask_r;

  out_item_t out_r;
  logic      out_valid_r;
  logic      out_free;

  add_req_t         add_req;
  logic [ADD_W:0]   add_sum;
  logic [TIME_W-1:0] sat_sum;

  logic [UB_W-1:0]  ub;
  logic             slot_mode;
  logic [1:0]       port_mod;
  logic [PW-1:0]    port_idx;
  logic [MSG_W-1:0] data_n, req_u, rsp_need_u, rsp_arr_u, msg_u_new;
  logic [Q_W:0]     req_sum;
  logic [Q_W+1:0]   rsp_sum;
  logic [Q_W-1:0]   deq_q;
  logic             deq_bad;
  status_t          chk_status;
  logic             chk_ok;
  logic             chk_set_retry;
  logic             div_ge;
  logic             is_rsp_dir;
  logic [MASK_W-1:0] mask_w;

  lfcas_addsub u_addsub (
    .req (add_req),
    .sum (add_sum)
  );

  // port index wrapped to the port count
  always_comb begin
    port_mod = item_r.port;
    for (int k = 0; k < 3; k++) begin
      if (int'(port_mod) >= NUM_PORTS) begin
        port_mod = port_mod - 2'(NUM_PORTS);
      end
    end
  end

  assign slot_mode  = (flit_r == SLOT_MODE_FLIT);
  assign ub         = slot_mode ? SLOT_UB : ((flit_r == '0) ? UB_W'(1) : flit_r);
  assign port_idx   = PW'(port_mod);
  assign is_rsp_dir = (op_r == OP_RSP_ARRIVE);
  assign div_ge     = add_sum[ADD_W];
  assign sat_sum    = add_sum[TIME_W] ? TIME_MAX : add_sum[TIME_W-1:0];
  assign out_free   = !out_valid_r || out_ch.ready;

  for (genvar g = 0; g < MASK_W; g++) begin : g_mask
    if (g < NUM_PORTS) begin : g_on
      assign mask_w[g] = retry_r[g];
    end else begin : g_off
      assign mask_w[g] = 1'b0;
    end
  end

  // shared adder operand select
  always_comb begin
    add_req = '0;
    case (state_r)
      S_DIV: begin
        add_req.a   = ADD_W'({rem_r, dvd_r[DVD_W-1]});
        add_req.b   = ~ADD_W'(ub);
        add_req.cin = 1'b1;
      end
      S_MUL1, S_MUL2: begin
        add_req.a = acc_r;
        add_req.b = mplier_r[0] ? mcand_r : '0;
      end
      S_ROUND: begin
        add_req.a   = ADD_W'(acc_r[ADD_W-1:FRAC_W]);
        add_req.cin = |acc_r[FRAC_W-1:0];
      end
      S_START: begin
        add_req.a   = ADD_W'(item_r.arrival_time);
        add_req.b   = ~ADD_W'(is_rsp_dir ? rsp_busy_r : req_busy_r);
        add_req.cin = 1'b1;
      end
      S_WAIT: begin
        add_req.a   = ADD_W'(start_r);
        add_req.b   = ~ADD_W'(item_r.arrival_time);
        add_req.cin = 1'b1;
      end
      S_BUSY: begin
        add_req.a = ADD_W'(start_r);
        add_req.b = ADD_W'(ser_r);
      end
      S_READY: begin
        add_req.a = ADD_W'(start_r);
        add_req.b = ADD_W'(is_rsp_dir ? rsp_lat_r : req_lat_r);
      end
      default: add_req = '0;
    endcase
  end

  // unit counts from the quotient
  always_comb begin
    data_n = MSG_W'(dvd_r) + MSG_W'(rem_r != '0);
    if (slot_mode && data_n == '0) begin
      data_n = MSG_W'(1);
    end
    req_u      = MSG_W'(req_hdr_r) + (item_r.is_write ? data_n : '0);
    rsp_need_u = item_r.needs_response ?
                 MSG_W'(rsp_hdr_r) + (item_r.response_will_carry_data ? data_n : '0) : '0;
    rsp_arr_u  = MSG_W'(rsp_hdr_r) + (item_r.carries_data ? data_n : '0);
    msg_u_new  = (op_r == OP_REQ_ARRIVE) ? req_u : rsp_arr_u;
  end

  // admission checks
  always_comb begin
    req_sum       = (Q_W+1)'(req_q_r) + (Q_W+1)'(msg_u_r);
    rsp_sum       = (Q_W+2)'(rsp_q_r) + (Q_W+2)'(res_r) + (Q_W+2)'(rsp_u_r);
    deq_q         = (op_r == OP_REQ_DEQ) ? req_q_r : rsp_q_r;
    deq_bad       = Q_W'(item_r.dequeue_units) > deq_q;
    chk_status    = ST_OK;
    chk_set_retry = 1'b0;
    case (op_r)
      OP_REQ_ARRIVE: begin
        if (retry_r[port_idx]) begin
          chk_status = ST_RETRY;
        end else if ((Q_W+1)'(msg_u_r) > (Q_W+1)'(req_depth_r) ||
                     (Q_W+1)'(rsp_u_r) > (Q_W+1)'(rsp_depth_r)) begin
          chk_status = ST_EXCEEDS;
        end else if (req_sum > (Q_W+1)'(req_depth_r)) begin
          chk_status    = ST_REQ_FULL;
          chk_set_retry = 1'b1;
        end else if (item_r.needs_response && rsp_sum > (Q_W+2)'(rsp_depth_r)) begin
          chk_status    = ST_RSP_FULL;
          chk_set_retry = 1'b1;
        end
      end
      OP_RSP_ARRIVE: begin
        if ((Q_W+1)'(msg_u_r) > (Q_W+1)'(rsp_depth_r)) begin
          chk_status = ST_EXCEEDS;
        end else if ((Q_W+1)'(res_r) < (Q_W+1)'(msg_u_r)) begin
          chk_status = ST_SHORT;
        end
      end
      default: begin
        if (deq_bad) begin
          chk_status = ST_UNDERFLOW;
        end
      end
    endcase
    chk_ok = (chk_status == ST_OK);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.data.opcode == OP_REQ_DEQ || in_ch.data.opcode == OP_RSP_DEQ) begin
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          state_nxt = S_UNITS;
        end
      end
      S_UNITS: state_nxt = S_CHECK;
      S_CHECK: begin
        if (chk_ok && (op_r == OP_REQ_ARRIVE || op_r == OP_RSP_ARRIVE)) begin
          state_nxt = S_MUL1;
        end else begin
          state_nxt = S_READY;
        end
      end
      S_MUL1: begin
        if (cnt_r == CNT_W'(MUL1_STEPS - 1)) begin
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        if (cnt_r == CNT_W'(MUL2_STEPS - 1)) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: state_nxt = S_START;
      S_START: state_nxt = S_WAIT;
      S_WAIT:  state_nxt = S_BUSY;
      S_BUSY:  state_nxt = S_READY;
      S_READY: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state, configuration and link state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      flit_r      <= UB_W'(256);
      tpb_r       <= TPB_W'(65536);
      req_lat_r   <= '0;
      rsp_lat_r   <= '0;
      req_hdr_r   <= HDR_W'(1);
      rsp_hdr_r   <= HDR_W'(1);
      req_depth_r <= Q_W'(64);
      rsp_depth_r <= Q_W'(64);
      req_busy_r  <= '0;
      rsp_busy_r  <= '0;
      req_q_r     <= '0;
      rsp_q_r     <= '0;
      res_r       <= '0;
      retry_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_FLIT_BYTES:  flit_r      <= cfg_wdata[UB_W-1:0];
          CFG_TICKS_PER_B: tpb_r       <= cfg_wdata[TPB_W-1:0];
          CFG_REQ_LATENCY: req_lat_r   <= cfg_wdata[LAT_W-1:0];
          CFG_RSP_LATENCY: rsp_lat_r   <= cfg_wdata[LAT_W-1:0];
          CFG_REQ_HDR:     req_hdr_r   <= cfg_wdata[HDR_W-1:0];
          CFG_RSP_HDR:     rsp_hdr_r   <= cfg_wdata[HDR_W-1:0];
          CFG_REQ_DEPTH:   req_depth_r <= cfg_wdata[Q_W-1:0];
          CFG_RSP_DEPTH:   rsp_depth_r <= cfg_wdata[Q_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_READY && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_CHECK) begin
        if (chk_set_retry) begin
          retry_r[port_idx] <= 1'b1;
        end
        if (chk_ok) begin
          case (op_r)
            OP_REQ_ARRIVE: begin
              res_r   <= res_r + Q_W'(rsp_u_r);
              req_q_r <= req_q_r + Q_W'(msg_u_r);
            end
            OP_RSP_ARRIVE: begin
              res_r   <= res_r - Q_W'(msg_u_r);
              rsp_q_r <= rsp_q_r + Q_W'(msg_u_r);
            end
            OP_REQ_DEQ: begin
              req_q_r <= req_q_r - Q_W'(item_r.dequeue_units);
              retry_r <= '0;
            end
            default: begin
              rsp_q_r <= rsp_q_r - Q_W'(item_r.dequeue_units);
              retry_r <= '0;
            end
          endcase
        end
      end
      if (state_r == S_BUSY) begin
        if (is_rsp_dir) begin
          rsp_busy_r <= sat_sum;
        end else begin
          req_busy_r <= sat_sum;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          item_r     <= in_ch.data;
          op_r       <= opcode_t'(in_ch.data.opcode);
          dvd_r      <= in_ch.data.size_bytes;
          rem_r      <= '0;
          cnt_r      <= '0;
          units_r    <= in_ch.data.dequeue_units;
          msg_u_r    <= '0;
          rsp_u_r    <= '0;
          accepted_r <= 1'b0;
          status_r   <= ST_OK;
          ser_r      <= '0;
          wait_r     <= '0;
          mask_r     <= '0;
        end
      end
      S_DIV: begin
        dvd_r <= {dvd_r[DVD_W-2:0], div_ge};
        rem_r <= div_ge ? add_sum[UB_W-1:0] : {rem_r[UB_W-2:0], dvd_r[DVD_W-1]};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      S_UNITS: begin
        msg_u_r <= msg_u_new;
        rsp_u_r <= rsp_need_u;
        units_r <= (msg_u_new > MSG_W'(UNITS_MAX)) ? UNITS_MAX : msg_u_new[UNITS_W-1:0];
      end
      S_CHECK: begin
        status_r   <= chk_status;
        accepted_r <= chk_ok;
        if (chk_ok && (op_r == OP_REQ_DEQ || op_r == OP_RSP_DEQ)) begin
          mask_r <= mask_w;
        end
        acc_r    <= '0;
        mcand_r  <= ADD_W'(msg_u_r);
        mplier_r <= TPB_W'(ub);
        cnt_r    <= '0;
      end
      S_MUL1: begin
        if (cnt_r == CNT_W'(MUL1_STEPS - 1)) begin
          acc_r    <= '0;
          mcand_r  <= add_sum[ADD_W-1:0];
          mplier_r <= tpb_r;
          cnt_r    <= '0;
        end else begin
          acc_r    <= add_sum[ADD_W-1:0];
          mcand_r  <= {mcand_r[ADD_W-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[TPB_W-1:1]};
          cnt_r    <= cnt_r + CNT_W'(1);
        end
      end
      S_MUL2: begin
        acc_r    <= add_sum[ADD_W-1:0];
        mcand_r  <= {mcand_r[ADD_W-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[TPB_W-1:1]};
        cnt_r    <= cnt_r + CNT_W'(1);
      end
      S_ROUND: ser_r <= add_sum[TIME_W-1:0];
      S_START: begin
        start_r <= div_ge ? item_r.arrival_time : (is_rsp_dir ? rsp_busy_r : req_busy_r);
      end
      S_WAIT: wait_r <= add_sum[TIME_W-1:0];
      S_BUSY: start_r <= sat_sum;
      S_READY: begin
        if (out_free) begin
          out_r.accepted        <= accepted_r;
          out_r.status          <= status_r;
          out_r.units           <= units_r;
          out_r.ready_time      <= (accepted_r &&
                                    (op_r == OP_REQ_ARRIVE || op_r == OP_RSP_ARRIVE)) ?
                                   sat_sum : '0;
          out_r.queue_wait      <= wait_r;
          out_r.serialize_ticks <= ser_r;
          out_r.retry_mask      <= mask_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

`ifndef SYNTHESIS
  a_accept_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.accepted == (out_ch.data.status == ST_OK)))
    else $error("accepted flag disagrees with status");

  a_reject_no_times: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.data.accepted) |->
      (out_ch.data.ready_time == '0 && out_ch.data.queue_wait == '0 &&
       out_ch.data.serialize_ticks == '0 && out_ch.data.retry_mask == '0))
    else $error("rejected beat carries schedule data");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UNITS) |-> (rem_r < ub))
    else $error("divider remainder not below unit size");

  a_dequeue_clears_retry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && chk_ok && (op_r == OP_REQ_DEQ || op_r == OP_RSP_DEQ))
      |=> (retry_r == '0))
    else $error("retry flags survive an accepted dequeue");
`endif

endmodule

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb
  import lfcas_pkg::*;
  ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PORTS   = 4;
  localparam int SLOT_SZ = 16;

  typedef struct {
    logic [DVD_W-1:0] size;
    logic             carries;
  } owed_rsp_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lfcas_in_if  in_ch ();
  lfcas_out_if out_ch ();

  link_flit_credit_admission_scheduler #(
    .NUM_PORTS (PORTS),
    .SLOT_LEN  (SLOT_SZ)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // register copy and link state
  logic [UB_W-1:0]  flit_sz   = UB_W'(256);
  logic [TPB_W-1:0] tick_rate = TPB_W'(65536);
  logic [LAT_W-1:0] req_lat   = '0;
  logic [LAT_W-1:0] rsp_lat   = '0;
  logic [HDR_W-1:0] req_hdr   = HDR_W'(1);
  logic [HDR_W-1:0] rsp_hdr   = HDR_W'(1);
  logic [Q_W-1:0]   req_depth = Q_W'(64);
  logic [Q_W-1:0]   rsp_depth = Q_W'(64);

  longint unsigned  req_busy = 0, rsp_busy = 0;
  longint unsigned  req_fill = 0, rsp_fill = 0, rsp_credit_held = 0;
  logic [PORTS-1:0] stalled = '0;

  in_item_t        beats_to_send [$];
  out_item_t       results_due [$];
  owed_rsp_t       owed [$];
  int              n_queued = 0, n_taken = 0, n_out = 0, n_bad = 0;
  longint unsigned tick_now = 0;

  function automatic longint unsigned unit_size();
    if (flit_sz == SLOT_MODE_FLIT) return SLOT_SZ;
    if (flit_sz == '0) return 1;
    return flit_sz;
  endfunction

  function automatic longint unsigned data_units_of(longint unsigned bytes);
    longint unsigned ub, n;
    ub = unit_size();
    n = (bytes + ub - 1) / ub;
    if (flit_sz == SLOT_MODE_FLIT && n == 0) n = 1;
    return n;
  endfunction

  function automatic longint unsigned sat_time(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > TIME_MAX) ? TIME_MAX : s;
  endfunction

  function automatic longint unsigned wire_ticks(longint unsigned units);
    longint unsigned prod, t;
    prod = units * unit_size() * tick_rate;
    t = (prod >> 16) + (((prod & 64'hFFFF) != 0) ? 1 : 0);
    return (t > TIME_MAX) ? TIME_MAX : t;
  endfunction

  function automatic void book_link(input bit rsp_dir, input longint unsigned arrival,
                                    input longint unsigned units, inout out_item_t r);
    longint unsigned busy, start, ser;
    busy = rsp_dir ? rsp_busy : req_busy;
    start = (arrival > busy) ? arrival : busy;
    ser = wire_ticks(units);
    busy = sat_time(start, ser);
    r.ready_time = TIME_W'(sat_time(busy, rsp_dir ? rsp_lat : req_lat));
    r.queue_wait = TIME_W'(start - arrival);
    r.serialize_ticks = TIME_W'(ser);
    if (rsp_dir) rsp_busy = busy;
    else req_busy = busy;
  endfunction

  function automatic out_item_t admit(in_item_t op);
    out_item_t       r;
    longint unsigned ru, pu, cnt, held;
    int              p;
    r = '0;
    p = op.port % PORTS;
    case (op.opcode)
      OP_REQ_ARRIVE: begin
        ru = req_hdr + (op.is_write ? data_units_of(op.size_bytes) : 0);
        pu = op.needs_response ?
             rsp_hdr + (op.response_will_carry_data ? data_units_of(op.size_bytes) : 0) : 0;
        cnt = ru;
        if (stalled[p]) begin
          r.status = ST_RETRY;
        end else if (ru > req_depth || pu > rsp_depth) begin
          r.status = ST_EXCEEDS;
        end else if (req_fill + ru > req_depth) begin
          r.status = ST_REQ_FULL;
          stalled[p] = 1'b1;
        end else if (op.needs_response && rsp_fill + rsp_credit_held + pu > rsp_depth) begin
          r.status = ST_RSP_FULL;
          stalled[p] = 1'b1;
        end else begin
          rsp_credit_held += pu;
          book_link(1'b0, op.arrival_time, ru, r);
          req_fill += ru;
          r.accepted = 1'b1;
        end
      end
      OP_RSP_ARRIVE: begin
        pu = rsp_hdr + (op.carries_data ? data_units_of(op.size_bytes) : 0);
        cnt = pu;
        if (pu > rsp_depth) begin
          r.status = ST_EXCEEDS;
        end else if (rsp_credit_held < pu) begin
          r.status = ST_SHORT;
        end else begin
          rsp_credit_held -= pu;
          book_link(1'b1, op.arrival_time, pu, r);
          rsp_fill += pu;
          r.accepted = 1'b1;
        end
      end
      default: begin
        cnt = op.dequeue_units;
        held = (op.opcode == OP_REQ_DEQ) ? req_fill : rsp_fill;
        if (cnt > held) begin
          r.status = ST_UNDERFLOW;
        end else begin
          if (op.opcode == OP_REQ_DEQ) req_fill -= cnt;
          else rsp_fill -= cnt;
          r.retry_mask = stalled;
          stalled = '0;
          r.accepted = 1'b1;
        end
      end
    endcase
    r.units = (cnt > UNITS_MAX) ? UNITS_MAX : UNITS_W'(cnt);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_bad++;
    end
  endtask

  // sender: bursts of beats with random gaps
  int   burst_left = 0;
  int   gap_left   = 0;
  logic in_fire    = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (gap_left > 0 || beats_to_send.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= beats_to_send[0];
        beats_to_send.delete(0);
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
    end
  end

  // receiver: own stall pattern plus two long hold-offs
  logic [15:0] rx_cyc     = '0;
  int          hold_left  = 0;
  int          long_holds = 0;

  always @(negedge clk) begin
    rx_cyc <= rx_cyc + 16'd1;
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if ((long_holds == 0 && n_out >= 150) || (long_holds == 1 && n_out >= 900)) begin
      out_ch.ready <= 1'b0;
      hold_left <= 600;
      long_holds <= long_holds + 1;
    end else begin
      case (rx_cyc[8:7])
        2'd0: out_ch.ready <= 1'b1;
        2'd1: out_ch.ready <= 1'($urandom);
        2'd2: out_ch.ready <= (rx_cyc[2:0] == 3'd0);
        default: out_ch.ready <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t want, got;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      n_out++;
      if (results_due.size() == 0) begin
        $error("result beat with no expected result pending");
        n_bad++;
      end else begin
        want = results_due[0];
        results_due.delete(0);
        check_field("accepted", TIME_W'(want.accepted), TIME_W'(got.accepted));
        check_field("status", TIME_W'(want.status), TIME_W'(got.status));
        check_field("units", TIME_W'(want.units), TIME_W'(got.units));
        check_field("ready_time", want.ready_time, got.ready_time);
        check_field("queue_wait", want.queue_wait, got.queue_wait);
        check_field("serialize_ticks", want.serialize_ticks, got.serialize_ticks);
        check_field("retry_mask", TIME_W'(want.retry_mask), TIME_W'(got.retry_mask));
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      results_due.push_back(admit(in_ch.data));
      n_taken++;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_FLIT_BYTES:  flit_sz   = v[UB_W-1:0];
      CFG_TICKS_PER_B: tick_rate = v[TPB_W-1:0];
      CFG_REQ_LATENCY: req_lat   = v[LAT_W-1:0];
      CFG_RSP_LATENCY: rsp_lat   = v[LAT_W-1:0];
      CFG_REQ_HDR:     req_hdr   = v[HDR_W-1:0];
      CFG_RSP_HDR:     rsp_hdr   = v[HDR_W-1:0];
      CFG_REQ_DEPTH:   req_depth = v[Q_W-1:0];
      default:         rsp_depth = v[Q_W-1:0];
    endcase
  endtask

  task automatic set_config(input int fb, input int unsigned tpb, input int rql, input int rsl,
                            input int rqh, input int rsh, input int rqd, input int rsd);
    write_reg(CFG_FLIT_BYTES, fb);
    write_reg(CFG_TICKS_PER_B, tpb);
    write_reg(CFG_REQ_LATENCY, rql);
    write_reg(CFG_RSP_LATENCY, rsl);
    write_reg(CFG_REQ_HDR, rqh);
    write_reg(CFG_RSP_HDR, rsh);
    write_reg(CFG_REQ_DEPTH, rqd);
    write_reg(CFG_RSP_DEPTH, rsd);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_op(input opcode_t opc, input int prt, input longint unsigned at,
                         input int sz, input bit wr, input bit nr, input bit rd,
                         input bit cd, input int dq);
    in_item_t op;
    op.opcode                   = opc;
    op.port                     = prt[1:0];
    op.arrival_time             = at[TIME_W-1:0];
    op.size_bytes               = sz[DVD_W-1:0];
    op.is_write                 = wr;
    op.needs_response           = nr;
    op.response_will_carry_data = rd;
    op.carries_data             = cd;
    op.dequeue_units            = dq[UNITS_W-1:0];
    beats_to_send.push_back(op);
    n_queued++;
  endtask

  // mostly request/response pairs with matching shapes, plus noise
  task automatic queue_random(input int count, input int size_hi, input int deq_hi);
    in_item_t  op;
    owed_rsp_t o;
    int        k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      op.opcode = (k < 36) ? OP_REQ_ARRIVE : (k < 60) ? OP_RSP_ARRIVE :
                  (k < 80) ? OP_REQ_DEQ : OP_RSP_DEQ;
      op.port = 2'($urandom);
      tick_now += $urandom_range(0, 60);
      if (tick_now > TIME_MAX) tick_now = TIME_MAX;
      if (tick_now > 100 && $urandom_range(0, 4) == 0)
        op.arrival_time = TIME_W'(tick_now - $urandom_range(0, 100));
      else
        op.arrival_time = TIME_W'(tick_now);
      k = $urandom_range(0, 19);
      if (k < 17) op.size_bytes = DVD_W'($urandom_range(0, size_hi));
      else if (k < 19) op.size_bytes = DVD_W'($urandom_range(0, 4096));
      else op.size_bytes = DVD_W'($urandom);
      op.is_write                 = 1'($urandom);
      op.needs_response           = 1'($urandom);
      op.response_will_carry_data = 1'($urandom);
      op.carries_data             = 1'($urandom);
      if ($urandom_range(0, 19) == 0) op.dequeue_units = UNITS_W'($urandom);
      else op.dequeue_units = UNITS_W'($urandom_range(0, deq_hi));
      if (op.opcode == OP_REQ_ARRIVE && op.needs_response) begin
        o.size = op.size_bytes;
        o.carries = op.response_will_carry_data;
        owed.push_back(o);
      end
      if (op.opcode == OP_RSP_ARRIVE && owed.size() > 0 && $urandom_range(0, 4) != 0) begin
        o = owed[0];
        owed.delete(0);
        op.size_bytes = o.size;
        op.carries_data = o.carries;
      end
      beats_to_send.push_back(op);
      n_queued++;
    end
  endtask

  task automatic settle();
    while (n_taken < n_queued || results_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    cfg_we      = 1'b0;
    cfg_addr    = CFG_FLIT_BYTES;
    cfg_wdata   = '0;
    in_ch.data  = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset values, slot accounting
    set_config(256, 65536, 0, 0, 1, 1, 64, 64);
    push_op(OP_REQ_ARRIVE, 0, 0, 0, 1, 1, 1, 0, 0);
    push_op(OP_REQ_ARRIVE, 1, 5, 4096, 1, 0, 0, 0, 0);
    push_op(OP_RSP_ARRIVE, 0, 40, 0, 0, 0, 0, 1, 0);
    push_op(OP_RSP_ARRIVE, 0, 41, 0, 0, 0, 0, 0, 0);
    push_op(OP_REQ_DEQ, 0, 0, 0, 0, 0, 0, 0, 8191);
    push_op(OP_REQ_ARRIVE, 1, 50, 1000, 1, 0, 0, 0, 0);
    push_op(OP_REQ_ARRIVE, 1, 60, 0, 0, 0, 0, 0, 0);
    push_op(OP_REQ_DEQ, 2, 0, 0, 0, 0, 0, 0, 2);
    push_op(OP_REQ_ARRIVE, 1, 80, 1000, 1, 0, 0, 0, 0);
    push_op(OP_REQ_ARRIVE, 2, 70, 0, 0, 0, 0, 0, 0);
    push_op(OP_RSP_DEQ, 3, 0, 0, 0, 0, 0, 0, 3);
    push_op(OP_RSP_DEQ, 3, 0, 0, 0, 0, 0, 0, 0);
    push_op(OP_RSP_DEQ, 1, 0, 0, 0, 0, 0, 0, 2);
    push_op(OP_REQ_DEQ, 0, 0, 0, 0, 0, 0, 0, 64);
    push_op(OP_REQ_ARRIVE, 3, 100, 1008, 0, 1, 1, 0, 0);
    push_op(OP_REQ_ARRIVE, 0, 110, 0, 0, 1, 0, 0, 0);
    push_op(OP_RSP_ARRIVE, 3, 120, 1008, 0, 0, 0, 1, 0);
    push_op(OP_RSP_DEQ, 1, 0, 0, 0, 0, 0, 0, 64);
    push_op(OP_RSP_ARRIVE, 2, 130, 1025, 0, 0, 0, 1, 0);
    push_op(OP_REQ_ARRIVE, 0, 140, 8191, 1, 1, 1, 0, 0);
    push_op(OP_REQ_ARRIVE, 2, 150, 16, 1, 1, 0, 0, 0);
    push_op(OP_REQ_ARRIVE, 3, 0, 17, 1, 0, 0, 0, 0);
    tick_now = 200;
    queue_random(300, 128, 8);
    settle();

    set_config(64, 32'h0001_8000, 100, 37, 2, 3, 200, 150);
    queue_random(350, 256, 6);
    settle();

    // widest settings, one-byte flits
    set_config(1, 32'hFFFF_FFFF, 65535, 65535, 15, 15, 65535, 65535);
    queue_random(350, 128, 150);
    settle();

    // zero flit size, free serialization, one-unit fifos
    set_config(0, 0, 0, 1, 1, 1, 1, 1);
    queue_random(150, 1, 1);
    settle();

    set_config(1024, $urandom, $urandom_range(0, 65535), $urandom_range(0, 65535),
               $urandom_range(1, 15), $urandom_range(1, 15),
               $urandom_range(16, 300), $urandom_range(16, 300));
    tick_now = {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF;
    queue_random(350, 2048, 20);
    settle();

    // times near the top of the range
    set_config(256, 32'hFFFF_FFFF, 65535, 65535, $urandom_range(1, 15),
               $urandom_range(1, 15), $urandom_range(64, 4000), $urandom_range(64, 4000));
    tick_now = TIME_MAX - 64'd30000;
    queue_random(350, 256, 20);
    settle();

    if (n_bad == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
